// File: rtl/ghm_pkg.sv
// Shared types, constants and helpers for the heightfield grid mesh block.
package ghm_pkg;

   localparam int MAX_DIM       = 1024;
   localparam int SAMPLE_BITS   = 24;
   localparam int DIM_BITS      = $clog2(MAX_DIM);
   localparam int SIZE_BITS     = DIM_BITS + 1;
   localparam int BOUND_BITS    = 24;
   localparam int SCALE_BITS    = 32;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int COORD_BITS    = 16;
   localparam int CORNER_BITS   = 22;
   localparam int Q_ONE         = 16384;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_X_SIZE  = 3'd0,
      CSR_Y_SIZE  = 3'd1,
      CSR_MIN_VAL = 3'd2,
      CSR_MAX_VAL = 3'd3,
      CSR_Y_SCALE = 3'd4,
      CSR_X_STEP  = 3'd5,
      CSR_Z_STEP  = 3'd6
   } ghm_csr_type;

   typedef struct packed {
      logic        [SIZE_BITS-1:0]  x_size;
      logic        [SIZE_BITS-1:0]  y_size;
      logic signed [BOUND_BITS-1:0] min_val;
      logic signed [BOUND_BITS-1:0] max_val;
      logic        [SCALE_BITS-1:0] y_scale;
      logic        [SCALE_BITS-1:0] x_step;
      logic        [SCALE_BITS-1:0] z_step;
   } ghm_cfg_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0]  vert_x;
      logic signed [COORD_BITS-1:0]  vert_y;
      logic signed [COORD_BITS-1:0]  vert_z;
      logic                          has_quad;
      logic        [CORNER_BITS-1:0] corner_sw;
      logic        [CORNER_BITS-1:0] corner_nw;
      logic        [CORNER_BITS-1:0] corner_ne;
      logic        [CORNER_BITS-1:0] corner_se;
   } ghm_vert_type;

   // Size register clamped to 2..MAX_DIM.
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] s);
      logic [SIZE_BITS-1:0] r;
      if (s < SIZE_BITS'(2)) begin
         r = SIZE_BITS'(2);
      end else if (s > SIZE_BITS'(MAX_DIM)) begin
         r = SIZE_BITS'(MAX_DIM);
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

// File: rtl/ghm_vertex.sv
// Vertex math for one sample: clip, height scale, grid coordinates, corner offsets.
module ghm_vertex
   import ghm_pkg::*;
(
   input  ghm_cfg_type                   cfg,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [DIM_BITS-1:0]    column,
   input  logic        [DIM_BITS-1:0]    row,
   output ghm_vert_type                  vert
);

   localparam int DIFF_BITS = BOUND_BITS + 1;
   localparam int YP_BITS   = DIFF_BITS + SCALE_BITS + 1;
   localparam int YS_BITS   = YP_BITS - 16;
   localparam int YO_BITS   = YS_BITS + 1;
   localparam int XP_BITS   = DIM_BITS + SCALE_BITS;
   localparam int XS_BITS   = XP_BITS - 16;
   localparam int RC_BITS   = DIM_BITS + SIZE_BITS;
   localparam int CW_BITS   = CORNER_BITS + 2;

   localparam logic signed [YO_BITS-1:0] YO_HI = YO_BITS'(Q_ONE);
   localparam logic signed [YO_BITS-1:0] YO_LO = -YO_BITS'(Q_ONE);

   logic        [SIZE_BITS-1:0]  xs;
   logic signed [BOUND_BITS-1:0] v_lo;
   logic signed [BOUND_BITS-1:0] v;
   logic signed [DIFF_BITS-1:0]  diff;
   logic signed [YP_BITS-1:0]    yp;
   logic signed [YS_BITS-1:0]    ys;
   logic signed [YO_BITS-1:0]    yo;
   logic        [XP_BITS-1:0]    xp;
   logic        [XS_BITS-1:0]    xq;
   logic        [XP_BITS-1:0]    zp;
   logic        [XS_BITS-1:0]    zq;
   logic        [DIM_BITS-1:0]   col_m1;
   logic        [DIM_BITS-1:0]   row_m1;
   logic        [RC_BITS-1:0]    rc;
   logic        [CW_BITS-1:0]    base;
   logic        [CW_BITS-1:0]    sw;
   logic        [CW_BITS-1:0]    nw;
   logic                         quad;

   // Sample is shorter or equal to the bound width.
   always_comb begin
      xs   = eff_size(cfg.x_size);
      v_lo = (BOUND_BITS'(sample) < cfg.min_val) ? cfg.min_val : BOUND_BITS'(sample);
      v    = (v_lo > cfg.max_val) ? cfg.max_val : v_lo;
      diff = $signed({v[BOUND_BITS-1], v}) - $signed({cfg.min_val[BOUND_BITS-1], cfg.min_val});
      yp   = diff * $signed({1'b0, cfg.y_scale});
      ys   = yp[YP_BITS-1:16];
      yo   = $signed({ys[YS_BITS-1], ys}) - YO_HI;

      if (cfg.min_val == cfg.max_val) begin
         vert.vert_y = '0;
      end else if (yo < YO_LO) begin
         vert.vert_y = -COORD_BITS'(Q_ONE);
      end else if (yo > YO_HI) begin
         vert.vert_y = COORD_BITS'(Q_ONE);
      end else begin
         vert.vert_y = yo[COORD_BITS-1:0];
      end

      xp = XP_BITS'(column) * XP_BITS'(cfg.x_step);
      xq = xp[XP_BITS-1:16];
      if (xq > XS_BITS'(2 * Q_ONE)) begin
         vert.vert_x = COORD_BITS'(Q_ONE);
      end else begin
         vert.vert_x = xq[COORD_BITS-1:0] - COORD_BITS'(Q_ONE);
      end

      zp = XP_BITS'(row) * XP_BITS'(cfg.z_step);
      zq = zp[XP_BITS-1:16];
      if (zq > XS_BITS'(2 * Q_ONE)) begin
         vert.vert_z = -COORD_BITS'(Q_ONE);
      end else begin
         vert.vert_z = COORD_BITS'(Q_ONE) - zq[COORD_BITS-1:0];
      end

      quad   = (column != '0) && (row != '0);
      col_m1 = column - DIM_BITS'(1);
      row_m1 = row - DIM_BITS'(1);
      rc     = RC_BITS'(row_m1) * RC_BITS'(xs);
      base   = CW_BITS'(rc) + CW_BITS'(col_m1);
      sw     = base * CW_BITS'(3);
      nw     = sw + CW_BITS'(xs) * CW_BITS'(3);

      vert.has_quad = quad;
      if (quad) begin
         vert.corner_sw = sw[CORNER_BITS-1:0];
         vert.corner_nw = nw[CORNER_BITS-1:0];
         vert.corner_ne = CORNER_BITS'(nw + CW_BITS'(3));
         vert.corner_se = CORNER_BITS'(sw + CW_BITS'(3));
      end else begin
         vert.corner_sw = '0;
         vert.corner_nw = '0;
         vert.corner_ne = '0;
         vert.corner_se = '0;
      end
   end

endmodule

// File: rtl/grid_heightfield_mesh.sv
// Top level: heightfield grid mesh vertex generator with config registers.
// Takes one matrix sample per cycle in row-major order and returns one mesh
// vertex per sample: x and z from the column and row counters, y from the
// clipped and scaled sample, plus the four corner offsets of the grid
// rectangle that the sample closes and a last-of-matrix flag. Sustained rate
// is one item per clock while rsp_stall stays low; a result is offered once
// its accepted sample has passed the input register and then the vertex math
// into the result register, whose multiply and saturate sets the clock.
// Stalls on the result side back up through the two registers to req_stall
// without loss.
// Write the registers only while the block is empty.
module grid_heightfield_mesh
   import ghm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_vert_x,
   output logic signed [COORD_BITS-1:0]  rsp_vert_y,
   output logic signed [COORD_BITS-1:0]  rsp_vert_z,
   output logic                          rsp_has_quad,
   output logic [CORNER_BITS-1:0]        rsp_corner_sw,
   output logic [CORNER_BITS-1:0]        rsp_corner_nw,
   output logic [CORNER_BITS-1:0]        rsp_corner_ne,
   output logic [CORNER_BITS-1:0]        rsp_corner_se,
   output logic                          rsp_frame_end
);

   ghm_cfg_type                   cfg_ff;

   logic [DIM_BITS-1:0]           col_ff,   col_in;
   logic [DIM_BITS-1:0]           row_ff,   row_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [DIM_BITS-1:0]           s1_col_ff;
   logic [DIM_BITS-1:0]           s1_row_ff;
   logic                          s1_end_ff;

   logic                          out_valid_ff, out_valid_in;
   ghm_vert_type                  out_vert_ff;
   logic                          out_end_ff;

   ghm_vert_type                  vert;
   logic [SIZE_BITS-1:0]          xs;
   logic [SIZE_BITS-1:0]          ys;
   logic                          col_end;
   logic                          row_end;
   logic                          out_free;
   logic                          s1_move;
   logic                          accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_size  <= SIZE_BITS'(2);
         cfg_ff.y_size  <= SIZE_BITS'(2);
         cfg_ff.min_val <= '0;
         cfg_ff.max_val <= '0;
         cfg_ff.y_scale <= '0;
         cfg_ff.x_step  <= SCALE_BITS'(64'h8000_0000);
         cfg_ff.z_step  <= SCALE_BITS'(64'h8000_0000);
      end else if (csr_wr_en) begin
         unique case (ghm_csr_type'(csr_index))
            CSR_X_SIZE:  cfg_ff.x_size  <= csr_wdata[SIZE_BITS-1:0];
            CSR_Y_SIZE:  cfg_ff.y_size  <= csr_wdata[SIZE_BITS-1:0];
            CSR_MIN_VAL: cfg_ff.min_val <= csr_wdata[BOUND_BITS-1:0];
            CSR_MAX_VAL: cfg_ff.max_val <= csr_wdata[BOUND_BITS-1:0];
            CSR_Y_SCALE: cfg_ff.y_scale <= csr_wdata[SCALE_BITS-1:0];
            CSR_X_STEP:  cfg_ff.x_step  <= csr_wdata[SCALE_BITS-1:0];
            CSR_Z_STEP:  cfg_ff.z_step  <= csr_wdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      xs       = eff_size(cfg_ff.x_size);
      ys       = eff_size(cfg_ff.y_size);
      col_end  = (SIZE_BITS'(col_ff) + SIZE_BITS'(1)) >= xs;
      row_end  = (SIZE_BITS'(row_ff) + SIZE_BITS'(1)) >= ys;

      out_free = !out_valid_ff || !rsp_stall;
      s1_move  = s1_valid_ff && out_free;
      req_stall = s1_valid_ff && !out_free;
      accept   = req_valid && !req_stall;

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + DIM_BITS'(1);
         end else begin
            col_in = col_ff + DIM_BITS'(1);
         end
      end

      s1_valid_in  = accept || (s1_valid_ff && !out_free);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= req_sample;
         s1_col_ff    <= col_ff;
         s1_row_ff    <= row_ff;
         s1_end_ff    <= col_end && row_end;
      end
      if (s1_move) begin
         out_vert_ff <= vert;
         out_end_ff  <= s1_end_ff;
      end
   end

   ghm_vertex u_vertex (
      .cfg    (cfg_ff),
      .sample (s1_sample_ff),
      .column (s1_col_ff),
      .row    (s1_row_ff),
      .vert   (vert)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_vert_x    = out_vert_ff.vert_x;
   assign rsp_vert_y    = out_vert_ff.vert_y;
   assign rsp_vert_z    = out_vert_ff.vert_z;
   assign rsp_has_quad  = out_vert_ff.has_quad;
   assign rsp_corner_sw = out_vert_ff.corner_sw;
   assign rsp_corner_nw = out_vert_ff.corner_nw;
   assign rsp_corner_ne = out_vert_ff.corner_ne;
   assign rsp_corner_se = out_vert_ff.corner_se;
   assign rsp_frame_end = out_end_ff;

endmodule

// File: sim/grid_heightfield_mesh_checker.sv
// Checker for the grid mesh block: predicts each vertex from the samples and compares results.
module grid_heightfield_mesh_checker
   import ghm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]       csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [COORD_BITS-1:0]  rsp_vert_x,
   input  logic signed [COORD_BITS-1:0]  rsp_vert_y,
   input  logic signed [COORD_BITS-1:0]  rsp_vert_z,
   input  logic                          rsp_has_quad,
   input  logic [CORNER_BITS-1:0]        rsp_corner_sw,
   input  logic [CORNER_BITS-1:0]        rsp_corner_nw,
   input  logic [CORNER_BITS-1:0]        rsp_corner_ne,
   input  logic [CORNER_BITS-1:0]        rsp_corner_se,
   input  logic                          rsp_frame_end,
   output int                            verts_in_flight,
   output int                            vertex_errors
);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] vert_x;
      logic signed [COORD_BITS-1:0] vert_y;
      logic signed [COORD_BITS-1:0] vert_z;
      logic                         has_quad;
      logic [CORNER_BITS-1:0]       corner_sw;
      logic [CORNER_BITS-1:0]       corner_nw;
      logic [CORNER_BITS-1:0]       corner_ne;
      logic [CORNER_BITS-1:0]       corner_se;
      logic                         frame_end;
   } mesh_vertex_type;

   ghm_cfg_type         grid_cfg;
   logic [DIM_BITS-1:0] col_pos;
   logic [DIM_BITS-1:0] row_pos;
   mesh_vertex_type     expected_verts[$];
   mesh_vertex_type     seen_vert;
   mesh_vertex_type     want_vert;

   function automatic longint clamp_dim(input logic [SIZE_BITS-1:0] s);
      if (s < 2) return 2;
      if (s > MAX_DIM) return MAX_DIM;
      return s;
   endfunction

   function automatic longint sat_q(input longint v);
      if (v < -Q_ONE) return -Q_ONE;
      if (v > Q_ONE) return Q_ONE;
      return v;
   endfunction

   function automatic mesh_vertex_type mesh_vertex_of(input logic signed [SAMPLE_BITS-1:0] s);
      mesh_vertex_type vt;
      longint xs, ys, lo, hi, lvl, col, row, sw, nw;
      xs  = clamp_dim(grid_cfg.x_size);
      ys  = clamp_dim(grid_cfg.y_size);
      lo  = $signed(grid_cfg.min_val);
      hi  = $signed(grid_cfg.max_val);
      col = col_pos;
      row = row_pos;
      lvl = s;
      // low bound first, so inverted bounds leave every sample at max_val
      if (lvl < lo) lvl = lo;
      if (lvl > hi) lvl = hi;
      vt = '0;
      if (lo != hi) begin
         vt.vert_y = COORD_BITS'(sat_q((((lvl - lo) * longint'(grid_cfg.y_scale)) >>> 16)
                                       - Q_ONE));
      end
      vt.vert_x = COORD_BITS'(sat_q(((col * longint'(grid_cfg.x_step)) >>> 16) - Q_ONE));
      vt.vert_z = COORD_BITS'(sat_q(Q_ONE - ((row * longint'(grid_cfg.z_step)) >>> 16)));
      if (col >= 1 && row >= 1) begin
         sw = 3 * ((col - 1) + (row - 1) * xs);
         nw = sw + 3 * xs;
         vt.has_quad  = 1'b1;
         vt.corner_sw = CORNER_BITS'(sw);
         vt.corner_nw = CORNER_BITS'(nw);
         vt.corner_ne = CORNER_BITS'(nw + 3);
         vt.corner_se = CORNER_BITS'(sw + 3);
      end
      vt.frame_end = (col + 1 >= xs) && (row + 1 >= ys);
      return vt;
   endfunction

   function automatic string vertex_text(input mesh_vertex_type vt);
      return $sformatf("x=%0d y=%0d z=%0d quad=%0b sw=%0d nw=%0d ne=%0d se=%0d end=%0b",
                       $signed(vt.vert_x), $signed(vt.vert_y), $signed(vt.vert_z),
                       vt.has_quad, vt.corner_sw, vt.corner_nw, vt.corner_ne,
                       vt.corner_se, vt.frame_end);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         grid_cfg.x_size  = SIZE_BITS'(2);
         grid_cfg.y_size  = SIZE_BITS'(2);
         grid_cfg.min_val = '0;
         grid_cfg.max_val = '0;
         grid_cfg.y_scale = '0;
         grid_cfg.x_step  = 32'h8000_0000;
         grid_cfg.z_step  = 32'h8000_0000;
         col_pos          = '0;
         row_pos          = '0;
         expected_verts.delete();
         vertex_errors    = 0;
         verts_in_flight  = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_X_SIZE:  grid_cfg.x_size  = csr_wdata[SIZE_BITS-1:0];
               CSR_Y_SIZE:  grid_cfg.y_size  = csr_wdata[SIZE_BITS-1:0];
               CSR_MIN_VAL: grid_cfg.min_val = csr_wdata[BOUND_BITS-1:0];
               CSR_MAX_VAL: grid_cfg.max_val = csr_wdata[BOUND_BITS-1:0];
               CSR_Y_SCALE: grid_cfg.y_scale = csr_wdata[SCALE_BITS-1:0];
               CSR_X_STEP:  grid_cfg.x_step  = csr_wdata[SCALE_BITS-1:0];
               CSR_Z_STEP:  grid_cfg.z_step  = csr_wdata[SCALE_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen_vert.vert_x    = rsp_vert_x;
            seen_vert.vert_y    = rsp_vert_y;
            seen_vert.vert_z    = rsp_vert_z;
            seen_vert.has_quad  = rsp_has_quad;
            seen_vert.corner_sw = rsp_corner_sw;
            seen_vert.corner_nw = rsp_corner_nw;
            seen_vert.corner_ne = rsp_corner_ne;
            seen_vert.corner_se = rsp_corner_se;
            seen_vert.frame_end = rsp_frame_end;
            if (expected_verts.size() == 0) begin
               if (vertex_errors < 10) begin
                  $display("unexpected vertex: %s", vertex_text(seen_vert));
               end
               vertex_errors++;
            end else begin
               want_vert = expected_verts.pop_front();
               if (seen_vert !== want_vert) begin
                  if (vertex_errors < 10) begin
                     $display("vertex mismatch\n  exp %s\n  got %s",
                              vertex_text(want_vert), vertex_text(seen_vert));
                  end
                  vertex_errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            expected_verts.push_back(mesh_vertex_of(req_sample));
            // a counter at or past its last position wraps on this item
            if (longint'(col_pos) + 1 >= clamp_dim(grid_cfg.x_size)) begin
               col_pos = '0;
               if (longint'(row_pos) + 1 >= clamp_dim(grid_cfg.y_size)) begin
                  row_pos = '0;
               end else begin
                  row_pos = row_pos + DIM_BITS'(1);
               end
            end else begin
               col_pos = col_pos + DIM_BITS'(1);
            end
         end
         verts_in_flight = expected_verts.size();
      end
   end

endmodule

// File: sim/grid_heightfield_mesh_tb.sv
// Testbench top for the grid mesh block: clock, reset, register setup, samples, idling, verdict.
module grid_heightfield_mesh_tb;
   import ghm_pkg::*;

   localparam int ITEM_TARGET    = 850;
   localparam int CALM_TAIL      = 90;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LEVEL_MIN      = -(1 << (BOUND_BITS - 1));
   localparam int LEVEL_MAX      = (1 << (BOUND_BITS - 1)) - 1;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0]       csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata   = '0;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample  = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   logic signed [COORD_BITS-1:0]  rsp_vert_x;
   logic signed [COORD_BITS-1:0]  rsp_vert_y;
   logic signed [COORD_BITS-1:0]  rsp_vert_z;
   logic                          rsp_has_quad;
   logic [CORNER_BITS-1:0]        rsp_corner_sw;
   logic [CORNER_BITS-1:0]        rsp_corner_nw;
   logic [CORNER_BITS-1:0]        rsp_corner_ne;
   logic [CORNER_BITS-1:0]        rsp_corner_se;
   logic                          rsp_frame_end;
   int                            verts_in_flight;
   int                            vertex_errors;

   bit idle_on        = 1'b1;
   int samples_sent   = 0;
   int stall_run      = 0;
   int quiet_cycles   = 0;

   grid_heightfield_mesh u_dut (.*);

   grid_heightfield_mesh_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // random bursts of result-side back-pressure while idling is on
   always @(posedge clock) begin
      if (stall_run > 1) begin
         stall_run <= stall_run - 1;
      end else if (stall_run == 1) begin
         stall_run <= 0;
         rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_run <= $urandom_range(1, 3);
         rsp_stall <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid  <= 1'b0;
         req_sample <= SAMPLE_BITS'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic write_reg(input ghm_csr_type idx, input logic [CSR_DATA_BITS-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // drains the block, then rewrites every register
   task automatic load_grid(input int xs, input int ys, input int lo, input int hi,
                            input logic [SCALE_BITS-1:0] ysc,
                            input logic [SCALE_BITS-1:0] xst,
                            input logic [SCALE_BITS-1:0] zst);
      req_valid <= 1'b0;
      @(negedge clock);
      while (verts_in_flight != 0) @(negedge clock);
      repeat (4) @(posedge clock);
      write_reg(CSR_X_SIZE, xs);
      write_reg(CSR_Y_SIZE, ys);
      write_reg(CSR_MIN_VAL, lo);
      write_reg(CSR_MAX_VAL, hi);
      write_reg(CSR_Y_SCALE, ysc);
      write_reg(CSR_X_STEP, xst);
      write_reg(CSR_Z_STEP, zst);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [SCALE_BITS-1:0] scale_for(input int span);
      if (span <= 0) return '0;
      return SCALE_BITS'((64'd1 << 31) / span);
   endfunction

   function automatic int any_level();
      return int'($urandom_range(0, (1 << BOUND_BITS) - 1)) + LEVEL_MIN;
   endfunction

   function automatic int pick_dim();
      case ($urandom_range(0, 15))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(MAX_DIM + 1, (1 << SIZE_BITS) - 1);
         2:       return MAX_DIM;
         3:       return $urandom_range(13, MAX_DIM - 1);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int lo, input int hi);
      int a, b;
      a = (lo < hi) ? lo : hi;
      b = (lo < hi) ? hi : lo;
      case ($urandom_range(0, 7))
         0, 1:    return SAMPLE_BITS'($urandom);
         2:       return SAMPLE_BITS'(lo);
         3:       return SAMPLE_BITS'(hi);
         4:       return SAMPLE_BITS'(a - 1 - int'($urandom_range(0, 3)));
         5:       return SAMPLE_BITS'(b + 1 + int'($urandom_range(0, 3)));
         default: return SAMPLE_BITS'(a + int'($urandom_range(0, b - a)));
      endcase
   endfunction

   initial begin
      int xs, ys, lo, hi, burst, tmp;
      logic [SCALE_BITS-1:0] ysc, xst, zst;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration as it stands
      send_sample(SAMPLE_BITS'(123));
      send_sample(SAMPLE_BITS'(-5));

      // full-range bounds, one whole 3x2 frame
      load_grid(3, 2, LEVEL_MIN, LEVEL_MAX, scale_for(LEVEL_MAX - LEVEL_MIN),
                scale_for(2), scale_for(1));
      send_sample(SAMPLE_BITS'(LEVEL_MIN));
      send_sample(SAMPLE_BITS'(LEVEL_MAX));
      send_sample(SAMPLE_BITS'(0));
      send_sample(SAMPLE_BITS'(-1));
      send_sample(SAMPLE_BITS'(24'h555555));
      send_sample(SAMPLE_BITS'(24'haaaaaa));

      // undersized sizes, clipping, oversized steps
      load_grid(0, 1, -100, 100, scale_for(200), 32'hffff_ffff, 32'hffff_ffff);
      send_sample(SAMPLE_BITS'(LEVEL_MIN));
      send_sample(SAMPLE_BITS'(LEVEL_MAX));
      send_sample(SAMPLE_BITS'(-101));
      send_sample(SAMPLE_BITS'(101));

      // oversized row length, inverted bounds
      load_grid((1 << SIZE_BITS) - 1, 2, 50, -50, 32'h0001_0000, '0, 32'h8000_0000);
      send_sample(SAMPLE_BITS'(0));
      send_sample(SAMPLE_BITS'(LEVEL_MAX));
      send_sample(SAMPLE_BITS'(LEVEL_MIN));

      // row shrinks under the column counter, equal bounds, zero steps
      load_grid(2, MAX_DIM, 7, 7, 32'hffff_ffff, '0, '0);
      send_sample(SAMPLE_BITS'(7));
      send_sample(SAMPLE_BITS'(LEVEL_MIN));
      send_sample(SAMPLE_BITS'(LEVEL_MAX));

      // largest legal row, zero height scale
      load_grid(MAX_DIM, 2, LEVEL_MIN, LEVEL_MAX, '0, scale_for(MAX_DIM - 1), scale_for(1));
      repeat (4) send_sample(SAMPLE_BITS'($urandom));

      while (samples_sent < ITEM_TARGET) begin
         idle_on = (samples_sent < ITEM_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         xs = pick_dim();
         ys = pick_dim();
         case ($urandom_range(0, 9))
            0: begin
               lo = any_level();
               hi = lo;
            end
            1: begin
               lo = any_level();
               hi = any_level();
               if (lo < hi) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
            end
            2: begin
               lo = LEVEL_MIN;
               hi = LEVEL_MAX;
            end
            default: begin
               lo = any_level();
               hi = lo + int'($urandom_range(1, $urandom_range(0, 1) ? 255 : 65535));
               if (hi > LEVEL_MAX) hi = LEVEL_MAX;
            end
         endcase
         ysc = scale_for(hi - lo);
         xst = scale_for(xs - 1);
         zst = scale_for(ys - 1);
         if ($urandom_range(0, 7) == 0) ysc = $urandom;
         if ($urandom_range(0, 7) == 0) xst = $urandom;
         if ($urandom_range(0, 7) == 0) zst = $urandom;
         load_grid(xs, ys, lo, hi, ysc, xst, zst);
         burst = $urandom_range(8, 40);
         repeat (burst) send_sample(pick_sample(lo, hi));
      end

      idle_on = 1'b0;
      req_valid <= 1'b0;
      @(negedge clock);
      while (verts_in_flight != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (vertex_errors == 0 && verts_in_flight == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
